@@ rtl/owts_pkg.sv @@
`default_nettype none

package owts_pkg;

  // One-wire ROM / function commands
  localparam logic [7:0] CmdSkipRom = 8'hCC;
  localparam logic [7:0] CmdConvert = 8'h44;
  localparam logic [7:0] CmdReadPad = 8'hBE;

  // Request kinds on the input stream
  localparam logic [1:0] ReqTick    = 2'd0;
  localparam logic [1:0] ReqConvert = 2'd1;
  localparam logic [1:0] ReqRead    = 2'd2;
  localparam logic [1:0] ReqFull    = 2'd3;

  localparam int unsigned CfgDataW = 20;
  localparam int unsigned CfgAddrW = 3;

  typedef enum logic [CfgAddrW-1:0] {
    CfgResetLow    = 3'd0,
    CfgPresWait    = 3'd1,
    CfgResetTail   = 3'd2,
    CfgShortLow    = 3'd3,
    CfgLongLow     = 3'd4,
    CfgReadSample  = 3'd5,
    CfgSlot        = 3'd6,
    CfgConvertWait = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [9:0]  reset_low_us;
    logic [9:0]  presence_wait_us;
    logic [9:0]  reset_tail_us;
    logic [7:0]  short_low_us;
    logic [7:0]  long_low_us;
    logic [7:0]  read_sample_us;
    logic [7:0]  slot_us;
    logic [19:0] convert_wait_us;
  } cfg_t;

  typedef enum logic [5:0] {
    PhIdle    = 6'b000001,
    PhRstLow  = 6'b000010,
    PhRstWait = 6'b000100,
    PhRstTail = 6'b001000,
    PhSlot    = 6'b010000,
    PhConv    = 6'b100000
  } phase_e;

endpackage

`default_nettype wire

@@ rtl/owts_cfg.sv @@
`default_nettype none

module owts_cfg
  import owts_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgAddrW-1:0] cfg_addr_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                     cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_low_us     <= 10'd480;
      cfg_q.presence_wait_us <= 10'd70;
      cfg_q.reset_tail_us    <= 10'd410;
      cfg_q.short_low_us     <= 8'd6;
      cfg_q.long_low_us      <= 8'd60;
      cfg_q.read_sample_us   <= 8'd15;
      cfg_q.slot_us          <= 8'd70;
      cfg_q.convert_wait_us  <= 20'd750000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CfgResetLow:    cfg_q.reset_low_us     <= cfg_data_i[9:0];
        CfgPresWait:    cfg_q.presence_wait_us <= cfg_data_i[9:0];
        CfgResetTail:   cfg_q.reset_tail_us    <= cfg_data_i[9:0];
        CfgShortLow:    cfg_q.short_low_us     <= cfg_data_i[7:0];
        CfgLongLow:     cfg_q.long_low_us      <= cfg_data_i[7:0];
        CfgReadSample:  cfg_q.read_sample_us   <= cfg_data_i[7:0];
        CfgSlot:        cfg_q.slot_us          <= cfg_data_i[7:0];
        CfgConvertWait: cfg_q.convert_wait_us  <= cfg_data_i;
        default:        cfg_q                  <= cfg_q;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ rtl/onewire_temp_sensor_master.sv @@
`default_nettype none
// One-wire temperature sensor master.
// Each item passes the input register and then the result register on its way to the result transfer.
// Throughput: one item per cycle unless the result side stalls; the sequencer state updates once per item.
// Reset (rst_ni, async active low): idle, counters and stored reading zero,
// timing registers at their default microsecond values.

module onewire_temp_sensor_master
  import owts_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // input stream
  input  wire logic                s_axis_tvalid_i,
  output      logic                s_axis_tready_o,
  input  wire logic [7:0]          s_axis_tdata_i,  // [1:0] req_type, [2] line_level
  // result stream
  output      logic                m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  output      logic [23:0]         m_axis_tdata_o,  // [0] drive_low, [1] busy_res,
                                                    // [2] done_res, [3] no_device,
                                                    // [19:4] temperature
  // configuration writes
  input  wire logic                cfg_we_i,
  input  wire logic [CfgAddrW-1:0] cfg_addr_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t cfg;

  owts_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // ---------------------------------------------------------------------------
  // Input register and flow control
  // ---------------------------------------------------------------------------
  logic       in_valid_q;
  logic [1:0] req_q;
  logic       line_q;
  logic       out_valid_q;
  logic       advance;

  // Item in the input register moves on when the result slot is free or drains
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      req_q  <= s_axis_tdata_i[1:0];
      line_q <= s_axis_tdata_i[2];
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer state
  // ---------------------------------------------------------------------------
  phase_e             phase_q, phase_d;
  logic [19:0]        cnt_q, cnt_d;
  logic [1:0]         kind_q, kind_d;
  logic [1:0]         bstep_q, bstep_d;   // 0 skip-ROM, 1 function, 2/3 read bytes
  logic [2:0]         bidx_q, bidx_d;
  logic [7:0]         shf_q, shf_d;
  logic [7:0]         lowb_q, lowb_d;
  logic signed [15:0] temp_q, temp_d;
  logic               pres_q, pres_d;

  // Effective reset, slot and sample timings: zero lengths act as one microsecond, sample point capped at the slot
  logic [9:0] rst_low_len, pres_len, tail_len;
  logic [7:0] slot_len, samp_raw, samp_pt;

  assign rst_low_len = (cfg.reset_low_us == '0) ? 10'd1 : cfg.reset_low_us;
  assign pres_len    = (cfg.presence_wait_us == '0) ? 10'd1 : cfg.presence_wait_us;
  assign tail_len    = (cfg.reset_tail_us == '0) ? 10'd1 : cfg.reset_tail_us;
  assign slot_len    = (cfg.slot_us == '0) ? 8'd1 : cfg.slot_us;
  assign samp_raw    = (cfg.read_sample_us == '0) ? 8'd1 : cfg.read_sample_us;
  assign samp_pt     = (samp_raw > slot_len) ? slot_len : samp_raw;

  logic [19:0] cnt_inc;
  logic [7:0]  shf_v;
  logic [2:0]  bidx_n;
  logic [7:0]  low_time;
  logic        done_d, nodev_d, drive_d;

  assign cnt_inc = cnt_q + 20'd1;

  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    kind_d   = kind_q;
    bstep_d  = bstep_q;
    bidx_d   = bidx_q;
    shf_d    = shf_q;
    lowb_d   = lowb_q;
    temp_d   = temp_q;
    pres_d   = pres_q;
    done_d   = 1'b0;
    nodev_d  = 1'b0;
    shf_v    = shf_q;
    bidx_n   = bidx_q + 3'd1;

    if (req_q != ReqTick) begin
      // commands only start from idle
      if (phase_q == PhIdle) begin
        kind_d  = req_q;
        pres_d  = 1'b0;
        phase_d = PhRstLow;
        cnt_d   = '0;
        bstep_d = 2'd0;
        bidx_d  = '0;
      end
    end else if (phase_q != PhIdle) begin
      cnt_d = cnt_inc;
      unique case (phase_q)
        PhRstLow: begin
          if (cnt_inc >= {10'd0, rst_low_len}) begin
            phase_d = PhRstWait;
            cnt_d   = '0;
          end
        end
        PhRstWait: begin
          if (cnt_inc >= {10'd0, pres_len}) begin
            pres_d  = !line_q;            // device pulls low when present
            phase_d = PhRstTail;
            cnt_d   = '0;
          end
        end
        PhRstTail: begin
          if (cnt_inc >= {10'd0, tail_len}) begin
            cnt_d = '0;
            if (!pres_q) begin
              phase_d = PhIdle;
              done_d  = 1'b1;
              nodev_d = 1'b1;
            end else begin
              bstep_d = 2'd0;
              phase_d = PhSlot;
              bidx_d  = '0;
              shf_d   = CmdSkipRom;
            end
          end
        end
        PhConv: begin
          if (cnt_inc >= cfg.convert_wait_us) begin
            phase_d = PhRstLow;
            cnt_d   = '0;
            bstep_d = 2'd0;
            bidx_d  = '0;
          end
        end
        PhSlot: begin
          // read slots shift the sampled bit in from the top
          if (bstep_q[1] && cnt_inc == {12'd0, samp_pt}) begin
            shf_v = {line_q, shf_q[7:1]};
          end
          if (cnt_inc >= {12'd0, slot_len}) begin
            if (!bstep_q[1]) begin
              shf_v = {1'b0, shf_v[7:1]};
            end
            bidx_d = bidx_n;
            cnt_d  = '0;
          end
          shf_d = shf_v;
          if (cnt_inc >= {12'd0, slot_len} && bidx_n == 3'd0) begin
            // byte boundary
            unique case (bstep_q)
              2'd0: begin
                bstep_d = 2'd1;
                bidx_d  = '0;
                shf_d   = (kind_q == ReqRead) ? CmdReadPad : CmdConvert;
              end
              2'd1: begin
                if (kind_q == ReqRead) begin
                  bstep_d = 2'd2;
                  bidx_d  = '0;
                  shf_d   = 8'h00;
                end else if (kind_q == ReqFull) begin
                  // second pass reads the scratchpad
                  kind_d = ReqRead;
                  if (cfg.convert_wait_us == '0) begin
                    phase_d = PhRstLow;
                    bstep_d = 2'd0;
                    bidx_d  = '0;
                  end else begin
                    phase_d = PhConv;
                  end
                end else begin
                  phase_d = PhIdle;
                  done_d  = 1'b1;
                end
              end
              2'd2: begin
                lowb_d  = shf_v;
                bstep_d = 2'd3;
                bidx_d  = '0;
                shf_d   = 8'h00;
              end
              default: begin
                temp_d  = signed'({shf_v, lowb_q});
                phase_d = PhIdle;
                done_d  = 1'b1;
              end
            endcase
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end

    // bus drive for the coming microsecond
    if (bstep_d[1]) begin
      low_time = cfg.short_low_us;
    end else begin
      low_time = shf_d[0] ? cfg.short_low_us : cfg.long_low_us;
    end
    if (phase_d == PhRstLow) begin
      drive_d = 1'b1;
    end else if (phase_d == PhSlot) begin
      drive_d = (cnt_d < {12'd0, low_time});
    end else begin
      drive_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      cnt_q   <= '0;
      kind_q  <= '0;
      bstep_q <= '0;
      bidx_q  <= '0;
      shf_q   <= '0;
      lowb_q  <= '0;
      temp_q  <= '0;
      pres_q  <= 1'b0;
    end else if (advance) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      kind_q  <= kind_d;
      bstep_q <= bstep_d;
      bidx_q  <= bidx_d;
      shf_q   <= shf_d;
      lowb_q  <= lowb_d;
      temp_q  <= temp_d;
      pres_q  <= pres_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic [19:0] res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= {temp_d, nodev_d, done_d, (phase_d != PhIdle), drive_d};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'd0, res_q};

endmodule

`default_nettype wire

@@ test/onewire_temp_sensor_master_tb.sv @@
`timescale 1ns / 1ps

module onewire_temp_sensor_master_tb;
  import owts_pkg::*;

  // Byte positions within one bus exchange: skip-ROM, function command,
  // then the two scratchpad bytes (low first).
  localparam logic [2:0] ByteSkip = 3'd0;
  localparam logic [2:0] ByteCmd  = 3'd1;
  localparam logic [2:0] ByteLow  = 3'd2;
  localparam logic [2:0] ByteHigh = 3'd3;

  // Result fields, last field in the lowest bit.
  typedef struct packed {
    logic signed [15:0] temperature;
    logic               no_device;
    logic               done;
    logic               busy;
    logic               drive_low;
  } bus_state_t;

  // Bus sequencer model plus the queue of results still owed by the block.
  class onewire_checker;
    cfg_t        timing;
    phase_e      phase;
    logic [19:0] count;
    logic [1:0]  kind;
    logic [2:0]  step;
    logic [2:0]  bit_idx;
    logic [7:0]  shifter;
    logic [7:0]  low_hold;
    logic [15:0] reading;
    logic        presence;
    int          errors;
    bus_state_t  expected_bus_states[$];

    function new();
      timing = '{reset_low_us: 10'd480, presence_wait_us: 10'd70, reset_tail_us: 10'd410,
                 short_low_us: 8'd6, long_low_us: 8'd60, read_sample_us: 8'd15,
                 slot_us: 8'd70, convert_wait_us: 20'd750000};
      phase    = PhIdle;
      count    = '0;
      kind     = '0;
      step     = ByteSkip;
      bit_idx  = '0;
      shifter  = '0;
      low_hold = '0;
      reading  = '0;
      presence = 1'b0;
      errors   = 0;
    endfunction

    // zero-length timings behave as one microsecond
    function logic [19:0] floor_one(logic [19:0] v);
      return (v == '0) ? 20'd1 : v;
    endfunction

    function void start_reset();
      phase   = PhRstLow;
      count   = '0;
      step    = ByteSkip;
      bit_idx = '0;
    endfunction

    function void load_byte(logic [7:0] v);
      phase   = PhSlot;
      count   = '0;
      bit_idx = '0;
      shifter = v;
    endfunction

    function void note_request(logic [1:0] req, logic lvl);
      bus_state_t  want;
      logic        fin;
      logic        nodev;
      logic [19:0] slot_end;
      logic [19:0] sample_at;
      logic [19:0] low_len;
      fin   = 1'b0;
      nodev = 1'b0;
      if (req != ReqTick) begin
        // commands only start from idle
        if (phase == PhIdle) begin
          kind     = req;
          presence = 1'b0;
          start_reset();
        end
      end else if (phase != PhIdle) begin
        count = count + 20'd1;
        case (phase)
          PhRstLow: begin
            if (count >= floor_one(20'(timing.reset_low_us))) begin
              phase = PhRstWait;
              count = '0;
            end
          end
          PhRstWait: begin
            if (count >= floor_one(20'(timing.presence_wait_us))) begin
              presence = !lvl;
              phase    = PhRstTail;
              count    = '0;
            end
          end
          PhRstTail: begin
            if (count >= floor_one(20'(timing.reset_tail_us))) begin
              if (!presence) begin
                phase = PhIdle;
                count = '0;
                fin   = 1'b1;
                nodev = 1'b1;
              end else begin
                step = ByteSkip;
                load_byte(CmdSkipRom);
              end
            end
          end
          PhConv: begin
            if (count >= timing.convert_wait_us) start_reset();
          end
          default: begin
            slot_end  = floor_one(20'(timing.slot_us));
            sample_at = floor_one(20'(timing.read_sample_us));
            if (sample_at > slot_end) sample_at = slot_end;
            if (step >= ByteLow && count == sample_at) shifter = {lvl, shifter[7:1]};
            if (count >= slot_end) begin
              if (step < ByteLow) shifter = shifter >> 1;
              bit_idx = bit_idx + 3'd1;
              count   = '0;
              if (bit_idx == 3'd0) begin
                case (step)
                  ByteSkip: begin
                    step = ByteCmd;
                    load_byte((kind == ReqRead) ? CmdReadPad : CmdConvert);
                  end
                  ByteCmd: begin
                    if (kind == ReqRead) begin
                      step = ByteLow;
                      load_byte(8'h00);
                    end else if (kind == ReqFull) begin
                      // second half of a full run behaves as a plain read
                      kind = ReqRead;
                      if (timing.convert_wait_us == '0) begin
                        start_reset();
                      end else begin
                        phase = PhConv;
                        count = '0;
                      end
                    end else begin
                      phase = PhIdle;
                      fin   = 1'b1;
                    end
                  end
                  ByteLow: begin
                    low_hold = shifter;
                    step     = ByteHigh;
                    load_byte(8'h00);
                  end
                  default: begin
                    reading = {shifter, low_hold};
                    phase   = PhIdle;
                    fin     = 1'b1;
                  end
                endcase
              end
            end
          end
        endcase
      end

      low_len = (step >= ByteLow || shifter[0]) ? 20'(timing.short_low_us)
                                                : 20'(timing.long_low_us);
      want.drive_low   = (phase == PhRstLow) || (phase == PhSlot && count < low_len);
      want.busy        = (phase != PhIdle);
      want.done        = fin;
      want.no_device   = nodev;
      want.temperature = reading;
      expected_bus_states.push_back(want);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= 50)
          $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      end
    endfunction

    function void check_result(logic [23:0] raw);
      bus_state_t got;
      bus_state_t want;
      got = raw[19:0];
      if (expected_bus_states.size() == 0) begin
        errors++;
        if (errors <= 50)
          $display("%0t: unexpected result, expected none, got %h", $time, raw);
        return;
      end
      want = expected_bus_states.pop_front();
      compare_field("drive_low", 16'(want.drive_low), 16'(got.drive_low));
      compare_field("busy", 16'(want.busy), 16'(got.busy));
      compare_field("done", 16'(want.done), 16'(got.done));
      compare_field("no_device", 16'(want.no_device), 16'(got.no_device));
      compare_field("temperature", want.temperature, got.temperature);
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [7:0]          s_axis_tdata_i = '0;   // [1:0] req_type, [2] line_level
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [23:0]         m_axis_tdata_o;        // [0] drive_low, [1] busy_res, [2] done_res,
                                              // [3] no_device, [19:4] temperature
  logic                cfg_we_i = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  onewire_checker board;
  int send_gap_pct   = 7;    // chance per check that the sender holds valid low before a transfer
  int recv_stall_pct = 79;   // chance per cycle that the result side is not ready
  int useful_items   = 0;    // items the sequencer actually acts on

  onewire_temp_sensor_master dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_data_i     (cfg_data_i)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Hard stop; the slowest legal run finishes well inside this.
  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

  // Result side: outputs are read as they stood at the edge, then the
  // ready for the next cycle is chosen.
  always @(posedge clk_i) begin
    if (m_axis_tvalid_o && m_axis_tready_i) board.check_result(m_axis_tdata_o);
    m_axis_tready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // One input transfer. Valid stays high on return so back-to-back items
  // need no re-raise; the model is advanced at the accepting edge.
  task automatic push_item(input logic [1:0] req, input logic lvl);
    if ((req == ReqTick) ? (board.phase != PhIdle) : (board.phase == PhIdle))
      useful_items++;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {5'b00000, lvl, req};
    do @(posedge clk_i); while (!s_axis_tready_o);
    board.note_request(req, lvl);
  endtask

  // Drop valid, let every owed result arrive, then cover the pipeline depth.
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    while (board.expected_bus_states.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes all eight timing registers; bits above each register's width get
  // junk, which the block must drop.
  task automatic load_timing(input cfg_t c);
    logic [CfgDataW-1:0] reg_word [8];
    reg_word[CfgResetLow]    = {10'($urandom), c.reset_low_us};
    reg_word[CfgPresWait]    = {10'($urandom), c.presence_wait_us};
    reg_word[CfgResetTail]   = {10'($urandom), c.reset_tail_us};
    reg_word[CfgShortLow]    = {12'($urandom), c.short_low_us};
    reg_word[CfgLongLow]     = {12'($urandom), c.long_low_us};
    reg_word[CfgReadSample]  = {12'($urandom), c.read_sample_us};
    reg_word[CfgSlot]        = {12'($urandom), c.slot_us};
    reg_word[CfgConvertWait] = c.convert_wait_us;
    for (int i = 0; i < 8; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_addr_i <= CfgAddrW'(i);
      cfg_data_i <= reg_word[i];
      @(posedge clk_i);
    end
    cfg_we_i     <= 1'b0;
    board.timing = c;
  endtask

  // One command and the ticks that carry it to idle. The line level plays a
  // sensor: presence per reset as asked, scratchpad bits from 'value', random
  // elsewhere. A noisy run drives the line at random throughout. Now and then
  // a command lands while busy and must be dropped.
  task automatic run_sequence(input logic [1:0] cmd, input bit first_ok, input bit second_ok,
                              input logic [15:0] value, input bit noisy);
    bit   ok;
    logic lvl;
    push_item(cmd, 1'($urandom));
    while (board.phase != PhIdle) begin
      if ($urandom_range(0, 49) == 0)
        push_item(2'($urandom_range(ReqConvert, ReqFull)), 1'($urandom));
      ok  = (cmd == ReqFull && board.kind == ReqRead) ? second_ok : first_ok;
      lvl = 1'($urandom);
      if (!noisy) begin
        if (board.phase == PhRstWait)
          lvl = !ok;
        else if (board.phase == PhSlot && board.step >= ByteLow)
          lvl = value[{board.step[0], board.bit_idx}];
      end
      push_item(ReqTick, lvl);
    end
  endtask

  initial begin
    cfg_t setting;
    int   mark;
    board = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Timings as they come out of reset: the start of a read, with the bus
    // held low through the first part of the long reset pulse.
    push_item(ReqRead, 1'b1);
    repeat (40) push_item(ReqTick, 1'($urandom));
    wait_drained();

    // All-zero timings: reset, slot and sample lengths act as one, reads sample at the first
    // microsecond, no convert wait. Directed extremes of the reading.
    send_gap_pct   = 79;
    recv_stall_pct = 7;
    load_timing('0);
    // the read begun above runs out at the short timings
    while (board.phase != PhIdle) push_item(ReqTick, 1'($urandom));
    push_item(ReqTick, 1'b0);
    push_item(ReqTick, 1'b1);
    run_sequence(ReqFull, 1'b1, 1'b1, 16'h8000, 1'b0);
    run_sequence(ReqRead, 1'b1, 1'b1, 16'h7FFF, 1'b0);
    run_sequence(ReqRead, 1'b1, 1'b1, 16'hFFFF, 1'b0);
    run_sequence(ReqRead, 1'b1, 1'b1, 16'h0000, 1'b0);
    run_sequence(ReqConvert, 1'b1, 1'b1, 16'h0000, 1'b0);
    run_sequence(ReqConvert, 1'b0, 1'b0, 16'h0000, 1'b0);
    run_sequence(ReqFull, 1'b1, 1'b0, 16'h1234, 1'b0);
    run_sequence(ReqRead, 1'b0, 1'b0, 16'h5A5A, 1'b0);
    wait_drained();

    // Low times past the slot end, sample point past the slot end, short
    // convert wait.
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    load_timing('{reset_low_us: 10'd1, presence_wait_us: 10'd2, reset_tail_us: 10'd1,
                  short_low_us: 8'd5, long_low_us: 8'd9, read_sample_us: 8'd7,
                  slot_us: 8'd3, convert_wait_us: 20'd2});
    run_sequence(ReqFull, 1'b1, 1'b1, 16'($urandom), 1'b0);
    wait_drained();

    // Upper extremes: only the start of a read, a whole exchange would take
    // thousands of microseconds; the next timing load lets it run out.
    send_gap_pct   = 7;
    recv_stall_pct = 79;
    load_timing('{reset_low_us: 10'd1023, presence_wait_us: 10'd1023,
                  reset_tail_us: 10'd1023, short_low_us: 8'd255, long_low_us: 8'd255,
                  read_sample_us: 8'd255, slot_us: 8'd255, convert_wait_us: 20'hFFFFF});
    push_item(ReqRead, 1'b1);
    repeat (60) push_item(ReqTick, 1'($urandom));
    wait_drained();

    // Random short timings; mostly clean exchanges with random readings,
    // some missing sensors and noisy lines.
    for (int p = 0; p < 3; p++) begin
      send_gap_pct   = (p % 3 == 0) ? 7 : (p % 3 == 1) ? 79 : 0;
      recv_stall_pct = (p % 3 == 0) ? 79 : (p % 3 == 1) ? 7 : 0;
      setting.reset_low_us     = 10'($urandom_range(0, 3));
      setting.presence_wait_us = 10'($urandom_range(0, 3));
      setting.reset_tail_us    = 10'($urandom_range(0, 3));
      setting.short_low_us     = 8'($urandom_range(0, 4));
      setting.long_low_us      = 8'($urandom_range(0, 6));
      setting.read_sample_us   = 8'($urandom_range(0, 5));
      setting.slot_us          = 8'($urandom_range(0, 4));
      setting.convert_wait_us  = 20'($urandom_range(0, 6));
      load_timing(setting);
      mark = useful_items;
      while (useful_items - mark < 60) begin
        repeat ($urandom_range(0, 3)) push_item(ReqTick, 1'($urandom));
        run_sequence(2'($urandom_range(ReqConvert, ReqFull)), $urandom_range(0, 7) != 0,
                     $urandom_range(0, 7) != 0, 16'($urandom), $urandom_range(0, 7) == 0);
      end
      wait_drained();
    end

    if (board.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
